### rtl/rlms_pkg.sv
// Package for the radio link mode supervisor.
// Holds payload structs, register indexes, reset values and controller types.
// No dependencies.
`default_nettype none
package rlms_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned LIMIT_W    = 3;
  localparam int unsigned TICK_W     = 7;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned NUM_W      = 15;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'd1;

  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST  = 3'd5;
  localparam logic [TICK_W-1:0]  WINDOW_TICKS_RST = 7'd100;
  localparam logic [CNT_W-1:0]   CNT_MAX          = 8'd255;
  localparam logic [NUM_W-1:0]   PERCENT          = 15'd100;

  localparam logic MODE_TX = 1'b0;
  localparam logic MODE_RX = 1'b1;

  typedef struct packed {
    logic func;
    logic flag_max_retry;
    logic flag_rx_ok;
    logic flag_tx_ok;
    logic frame_valid;
    logic no_signal;
  } in_item_t;

  typedef struct packed {
    logic             radio_mode;
    logic             mode_write;
    logic             send_frame;
    logic             tx_flush;
    logic             read_payload;
    logic             set_idle;
    logic             clear_status;
    logic [CNT_W-1:0] link_rate;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic step;
    logic div_run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/rlms_ctrl.sv
// Controller state machine of the radio link mode supervisor.
// Sequences step, divide and result transfer; uses rlms_pkg.
`default_nettype none
module rlms_ctrl
  import rlms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.step    = 1'b0;
    cmd.div_run = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = stat.need_div ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/rlms_dp.sv
// Datapath of the radio link mode supervisor: configuration, link state,
// step logic, result register and a restoring divider; uses rlms_pkg.
`default_nettype none
module rlms_dp
  import rlms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire in_item_t              in_data,
  output out_item_t                  out_data,
  input  wire ctrl_cmd_t             cmd,
  output dp_stat_t                   stat
);

  logic [LIMIT_W-1:0]   retry_limit_r;
  logic [TICK_W-1:0]    window_ticks_r;
  logic                 mode_rx_r,       mode_rx_nxt;
  logic [LIMIT_W-1:0]   retry_count_r,   retry_count_nxt;
  logic [TICK_W-1:0]    tick_count_r,    tick_count_nxt;
  logic [CNT_W-1:0]     sent_count_r,    sent_count_nxt;
  logic [CNT_W-1:0]     success_count_r, success_count_nxt;
  logic [CNT_W-1:0]     rate_value_r,    rate_value_nxt;
  out_item_t            out_r,           out_nxt;

  logic [NUM_W-1:0]     num_r;
  logic [CNT_W-1:0]     den_r;
  logic [CNT_W-1:0]     rem_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [LIMIT_W:0]     retry_inc;
  logic                 retry_over;
  logic [LIMIT_W-1:0]   retry_bumped;
  logic [TICK_W:0]      tick_inc;
  logic                 window_end;
  logic [CNT_W-1:0]     sent_after;
  logic                 need_div;

  logic [CNT_W:0]       rem_sh;
  logic                 quo_bit;
  logic [CNT_W:0]       rem_sub;
  logic [NUM_W-1:0]     quo_final;
  logic [CNT_W-1:0]     rate_div;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r  <= RETRY_LIMIT_RST;
      window_ticks_r <= WINDOW_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RETRY_LIMIT:  retry_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        CFG_WINDOW_TICKS: window_ticks_r <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    retry_inc    = {1'b0, retry_count_r} + 1'b1;
    retry_over   = retry_inc > {1'b0, retry_limit_r};
    retry_bumped = retry_over ? '0 : retry_inc[LIMIT_W-1:0];
    tick_inc     = {1'b0, tick_count_r} + 1'b1;
    window_end   = tick_inc > {1'b0, window_ticks_r};
    sent_after   = sent_count_r;
    if (mode_rx_r == MODE_TX && sent_count_r != CNT_MAX) begin
      sent_after = sent_count_r + 1'b1;
    end
    need_div = !in_data.func && window_end && (sent_after != '0);
  end

  always_comb begin
    mode_rx_nxt       = mode_rx_r;
    retry_count_nxt   = retry_count_r;
    tick_count_nxt    = tick_count_r;
    sent_count_nxt    = sent_count_r;
    success_count_nxt = success_count_r;
    rate_value_nxt    = rate_value_r;
    out_nxt           = '0;
    if (in_data.func) begin
      out_nxt.clear_status = 1'b1;
      if (in_data.flag_max_retry) begin
        out_nxt.tx_flush = 1'b1;
        if (!in_data.no_signal) begin
          retry_count_nxt = retry_bumped;
          if (retry_over) begin
            mode_rx_nxt        = MODE_RX;
            out_nxt.mode_write = 1'b1;
          end
        end
      end else if (in_data.flag_rx_ok) begin
        out_nxt.read_payload = 1'b1;
        if (in_data.frame_valid) begin
          retry_count_nxt    = '0;
          mode_rx_nxt        = MODE_TX;
          out_nxt.mode_write = 1'b1;
        end
      end else if (in_data.flag_tx_ok) begin
        out_nxt.tx_flush   = 1'b1;
        retry_count_nxt    = '0;
        if (success_count_r != CNT_MAX) begin
          success_count_nxt = success_count_r + 1'b1;
        end
        mode_rx_nxt        = MODE_RX;
        out_nxt.mode_write = 1'b1;
        out_nxt.set_idle   = in_data.no_signal;
      end
    end else begin
      if (mode_rx_r == MODE_TX) begin
        out_nxt.send_frame = 1'b1;
        sent_count_nxt     = sent_after;
      end else begin
        retry_count_nxt = retry_bumped;
        if (retry_over) begin
          mode_rx_nxt        = MODE_TX;
          out_nxt.mode_write = 1'b1;
        end
      end
      if (window_end) begin
        if (sent_after == '0) begin
          rate_value_nxt = '0;
        end
        tick_count_nxt    = '0;
        sent_count_nxt    = '0;
        success_count_nxt = '0;
      end else begin
        tick_count_nxt = tick_inc[TICK_W-1:0];
      end
    end
    out_nxt.radio_mode = mode_rx_nxt;
    out_nxt.link_rate  = rate_value_nxt;
  end

  always_comb begin
    rem_sh    = {rem_r, num_r[NUM_W-1]};
    quo_bit   = rem_sh >= {1'b0, den_r};
    rem_sub   = quo_bit ? (rem_sh - {1'b0, den_r}) : rem_sh;
    quo_final = {quo_r[NUM_W-2:0], quo_bit};
    rate_div  = (quo_final[NUM_W-1:CNT_W] != '0) ? CNT_MAX : quo_final[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_rx_r       <= MODE_TX;
      retry_count_r   <= '0;
      tick_count_r    <= '0;
      sent_count_r    <= '0;
      success_count_r <= '0;
      rate_value_r    <= '0;
    end else if (cmd.step) begin
      mode_rx_r       <= mode_rx_nxt;
      retry_count_r   <= retry_count_nxt;
      tick_count_r    <= tick_count_nxt;
      sent_count_r    <= sent_count_nxt;
      success_count_r <= success_count_nxt;
      rate_value_r    <= rate_value_nxt;
    end else if (cmd.div_run && stat.div_last) begin
      rate_value_r <= rate_div;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_r     <= out_nxt;
      num_r     <= {{(NUM_W-CNT_W){1'b0}}, success_count_r} * PERCENT;
      den_r     <= sent_after;
      rem_r     <= '0;
      quo_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_run) begin
      num_r     <= {num_r[NUM_W-2:0], 1'b0};
      rem_r     <= rem_sub[CNT_W-1:0];
      quo_r     <= quo_final;
      div_cnt_r <= div_cnt_r + 1'b1;
      if (stat.div_last) begin
        out_r.link_rate <= rate_div;
      end
    end
  end

  assign stat.need_div = need_div;
  assign stat.div_last = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign out_data      = out_r;

endmodule
`default_nettype wire

### rtl/radio_link_mode_supervisor.sv
// Top level of the radio link mode supervisor.
// Joins the controller rlms_ctrl and the datapath rlms_dp; uses rlms_pkg.
//
// Each accepted tick or radio interrupt gives exactly one result. Without a
// divide the result is offered in the cycle after the input transfer, and
// the block takes its next input in the cycle after the result transfer. A
// tick that closes a measurement window with frames sent first runs a
// restoring divider, one quotient bit a cycle, in state ST_DIV before the
// result is offered. Configuration writes go straight into the registers.
`default_nettype none
module radio_link_mode_supervisor
  import rlms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rlms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire
